// File: rtl/core/sst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Small set table package
// Shared sizes, operation codes, controller states and the memory request
// bundle used by the small set table.
// ----------------------------------------------------------------------------
package sst_pkg;

    // Capacity of the set.
    localparam int DEPTH = 16;

    // Widths derived from the capacity.
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int HELD_W  = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;
    localparam int FUNC_W  = 2;

    // Operation codes carried on the func port.
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_MOVE
    } state_t;

    // One cycle of requests from the controller to the entry memory.
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
    } mem_req_t;

endpackage
`default_nettype wire

// File: rtl/core/sst_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Small set table entry memory
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module sst_mem (
    input  wire logic                         clk,
    input  wire sst_pkg::mem_req_t            req,
    output logic [sst_pkg::DATA_W-1:0]        rd_data
);

    logic [sst_pkg::DATA_W-1:0] mem_array [sst_pkg::DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_array[req.wr_addr] <= req.wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem_array[req.rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/sst_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Small set table controller
// Searches the held entries one per cycle, then inserts, removes by moving
// the last entry into the found slot, or just reports membership.
// ----------------------------------------------------------------------------
module sst_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [sst_pkg::FUNC_W-1:0]    func,
    input  wire logic [sst_pkg::DATA_W-1:0]    value,
    output logic                               busy,
    output logic                               done,
    output logic                               found,
    output logic [sst_pkg::COUNT_W-1:0]        count,
    output logic                               dropped,
    output sst_pkg::mem_req_t                  mem_req,
    input  wire logic [sst_pkg::DATA_W-1:0]    rd_data
);

    sst_pkg::state_t                 state_reg, state_next;
    logic [sst_pkg::HELD_W-1:0]      held_reg, held_next;
    logic                            done_reg, done_next;
    logic [sst_pkg::FUNC_W-1:0]      func_reg, func_next;
    logic [sst_pkg::DATA_W-1:0]      value_reg, value_next;
    logic [sst_pkg::ADDR_W-1:0]      idx_reg, idx_next;
    logic [sst_pkg::ADDR_W-1:0]      slot_reg, slot_next;
    logic                            hit_reg, hit_next;
    logic                            found_reg, found_next;
    logic                            dropped_reg, dropped_next;
    logic [sst_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic [sst_pkg::HELD_W-1:0]      idx_plus;
    logic                            accept;

    assign accept   = start && (state_reg == sst_pkg::ST_IDLE);
    assign idx_plus = sst_pkg::HELD_W'(idx_reg) + sst_pkg::HELD_W'(1);

    // Next state and next values of the working registers.
    always_comb
    begin
        state_next   = state_reg;
        held_next    = held_reg;
        done_next    = 1'b0;
        func_next    = func_reg;
        value_next   = value_reg;
        idx_next     = idx_reg;
        slot_next    = slot_reg;
        hit_next     = hit_reg;
        found_next   = found_reg;
        dropped_next = dropped_reg;
        count_next   = count_reg;
        unique case (state_reg)
            sst_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    func_next  = func;
                    value_next = value;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    if (held_reg == '0)
                    begin
                        state_next = sst_pkg::ST_DECIDE;
                    end
                    else
                    begin
                        state_next = sst_pkg::ST_SEARCH;
                    end
                end
            end
            sst_pkg::ST_SEARCH:
            begin
                if (rd_data == value_reg)
                begin
                    hit_next   = 1'b1;
                    slot_next  = idx_reg;
                    state_next = sst_pkg::ST_DECIDE;
                end
                else if (idx_plus == held_reg)
                begin
                    state_next = sst_pkg::ST_DECIDE;
                end
                else
                begin
                    idx_next = sst_pkg::ADDR_W'(idx_plus);
                end
            end
            sst_pkg::ST_DECIDE:
            begin
                found_next   = hit_reg;
                dropped_next = 1'b0;
                state_next   = sst_pkg::ST_IDLE;
                done_next    = 1'b1;
                case (func_reg)
                    sst_pkg::FUNC_ADD:
                    begin
                        if (!hit_reg)
                        begin
                            if (held_reg < sst_pkg::HELD_W'(sst_pkg::DEPTH))
                            begin
                                held_next = held_reg + sst_pkg::HELD_W'(1);
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                    end
                    sst_pkg::FUNC_REMOVE:
                    begin
                        // The last entry must be read before it moves.
                        if (hit_reg)
                        begin
                            state_next = sst_pkg::ST_MOVE;
                            done_next  = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                count_next = sst_pkg::COUNT_W'(held_next);
            end
            sst_pkg::ST_MOVE:
            begin
                held_next  = held_reg - sst_pkg::HELD_W'(1);
                count_next = sst_pkg::COUNT_W'(held_next);
                state_next = sst_pkg::ST_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = sst_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory requests for the current state.
    always_comb
    begin
        mem_req         = '0;
        mem_req.wr_data = value_reg;
        unique case (state_reg)
            sst_pkg::ST_IDLE:
            begin
                mem_req.rd_en   = accept;
                mem_req.rd_addr = '0;
            end
            sst_pkg::ST_SEARCH:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = sst_pkg::ADDR_W'(idx_plus);
            end
            sst_pkg::ST_DECIDE:
            begin
                if ((func_reg == sst_pkg::FUNC_ADD) && !hit_reg &&
                    (held_reg < sst_pkg::HELD_W'(sst_pkg::DEPTH)))
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = sst_pkg::ADDR_W'(held_reg);
                end
                if ((func_reg == sst_pkg::FUNC_REMOVE) && hit_reg)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = sst_pkg::ADDR_W'(held_reg - sst_pkg::HELD_W'(1));
                end
            end
            sst_pkg::ST_MOVE:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = slot_reg;
                mem_req.wr_data = rd_data;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sst_pkg::ST_IDLE;
            held_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        value_reg   <= value_next;
        idx_reg     <= idx_next;
        slot_reg    <= slot_next;
        hit_reg     <= hit_next;
        found_reg   <= found_next;
        dropped_reg <= dropped_next;
        count_reg   <= count_next;
    end

    assign busy    = (state_reg != sst_pkg::ST_IDLE);
    assign done    = done_reg;
    assign found   = found_reg;
    assign count   = count_reg;
    assign dropped = dropped_reg;

endmodule
`default_nettype wire

// File: rtl/core/small_set_table_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Small set table unit
// Set of up to sixteen distinct 32-bit values with add, remove and query.
// ----------------------------------------------------------------------------
// An operation is taken when start is high while busy is low. The held
// entries sit in a single-port-read memory and are compared one per cycle,
// and the search stops at the first match or after the last held entry; a
// remove that hits then reads the last entry before moving it into the
// found slot. The result is shown for exactly one cycle with done high; the
// receiver cannot stall it, and a new operation may start in that same cycle.
// ----------------------------------------------------------------------------
module small_set_table_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [sst_pkg::FUNC_W-1:0]    func,
    input  wire logic signed [sst_pkg::DATA_W-1:0] value,
    output logic                               done,
    output logic                               found,
    output logic [sst_pkg::COUNT_W-1:0]        count,
    output logic                               dropped
);

    sst_pkg::mem_req_t           mem_req;
    logic [sst_pkg::DATA_W-1:0]  rd_data;

    // Search and update sequencer.
    sst_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .func    (func),
        .value   (value),
        .busy    (busy),
        .done    (done),
        .found   (found),
        .count   (count),
        .dropped (dropped),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    // Entry storage.
    sst_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

endmodule
`default_nettype wire
